>>> hdl/bmp24_pixel_stream_decoder_core_defines.svh
// assertion macros for the checker file
`ifndef BMP24_PIXEL_STREAM_DECODER_CORE_DEFINES_SVH
`define BMP24_PIXEL_STREAM_DECODER_CORE_DEFINES_SVH

// same-cycle implication, quiet while reset is low
`define BMP24_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bmp24 assertion failed");

// next-cycle implication, quiet while reset is low
`define BMP24_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bmp24 assertion failed");

`endif

>>> hdl/bmp24_pkg.sv
`default_nettype none
package bmp24_pkg;

    // header layout
    localparam logic [7:0]  SIG_B       = 8'h42;
    localparam logic [7:0]  SIG_M       = 8'h4D;
    localparam logic [31:0] SIG_POS_B   = 32'd0;
    localparam logic [31:0] SIG_POS_M   = 32'd1;
    localparam logic [31:0] OFFS_POS    = 32'd10;
    localparam logic [31:0] WIDTH_POS   = 32'd18;
    localparam logic [31:0] HEIGHT_POS  = 32'd22;
    localparam logic [31:0] HDR_END     = 32'd26;
    localparam logic [31:0] POS_MAX     = 32'hFFFF_FFFF;

    // image size bound
    localparam logic [31:0] MAX_WIDTH   = 32'd4096;
    localparam logic [31:0] MAX_HEIGHT  = 32'd4096;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam int          COORD_W      = 12;

    // pixel phases
    localparam logic [1:0]  PH_FIRST  = 2'd0;
    localparam logic [1:0]  PH_SECOND = 2'd1;
    localparam logic [1:0]  PH_THIRD  = 2'd2;

    // result payload, red in the lowest bits
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column;
        logic [7:0]         alpha;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
    } t_pixel;

    localparam int PIX_W = $bits(t_pixel);

endpackage
`default_nettype wire

>>> hdl/bmp24_pixel_stream_decoder_core.sv
// the byte that completes a pixel passes the input register and then the result register to the master side
// throughput: one byte per cycle while the master side does not stall, one pixel per three pixel bytes
// the parse state is updated by one stage of logic between the input and result registers
// reset (i_rst_n low, synchronous) empties both registers and leaves the parser idle
// until a byte flagged as file start arrives
`default_nettype none
module bmp24_pixel_stream_decoder_core
    import bmp24_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // byte stream
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [7:0] data_byte
    input  wire logic               s_axis_tuser,   // [0] file_start
    // pixel stream
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [PIX_W-1:0]        m_axis_tdata,   // red, green, blue, alpha, column, row
    output logic                    m_axis_tlast,   // last_pixel
    output logic                    m_axis_tuser    // [0] bad_signature
);

    // input register
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_start;

    // result register
    logic               r_out_valid;
    t_pixel             r_out_pix;
    logic               r_out_last;
    logic               r_out_bad;

    // parse state
    logic [31:0]        r_pos,    n_pos;
    logic [31:0]        r_offset, n_offset;
    logic [31:0]        r_width,  n_width;
    logic [31:0]        r_height, n_height;
    logic               r_sigerr, n_sigerr;
    logic [1:0]         r_phase,  n_phase;
    logic [7:0]         r_held1,  n_held1;
    logic [7:0]         r_held2,  n_held2;
    logic [COORD_W-1:0] r_col,    n_col;
    logic [COORD_W-1:0] r_row,    n_row;
    logic [1:0]         r_pad,    n_pad;
    logic               r_done,   n_done;

    logic               w_adv;    // result register can take a new value
    logic               w_fire;   // held byte is processed this cycle
    logic               w_emit;
    logic               w_last;
    t_pixel             w_pix;

    assign w_adv  = !r_out_valid || m_axis_tready;
    assign w_fire = r_in_valid && w_adv;

    // the input register frees itself whenever its byte moves on; while a finished pixel
    // still waits on the master side, a byte is taken only if the input register is empty
    assign s_axis_tready = !r_in_valid || w_adv;

    // parse one byte
    always_comb begin
        logic [31:0] v_pos;
        logic [31:0] v_rel;
        logic        v_row_end;
        logic        v_size_bad;

        n_pos    = r_pos;
        n_offset = r_offset;
        n_width  = r_width;
        n_height = r_height;
        n_sigerr = r_sigerr;
        n_phase  = r_phase;
        n_held1  = r_held1;
        n_held2  = r_held2;
        n_col    = r_col;
        n_row    = r_row;
        n_pad    = r_pad;
        n_done   = r_done;
        w_emit   = 1'b0;
        w_last   = 1'b0;
        v_pos    = '0;
        v_rel    = '0;
        v_row_end  = 1'b0;
        v_size_bad = 1'b0;

        w_pix.red    = r_in_byte;
        w_pix.green  = r_held2;
        w_pix.blue   = r_held1;
        w_pix.alpha  = ALPHA_OPAQUE;
        w_pix.column = r_col;
        w_pix.row    = r_row;

        if (w_fire) begin
            // file start restarts the parse on this very byte
            if (r_in_start) begin
                n_pos    = '0;
                n_offset = '0;
                n_width  = '0;
                n_height = '0;
                n_sigerr = 1'b0;
                n_phase  = PH_FIRST;
                n_held1  = '0;
                n_held2  = '0;
                n_col    = '0;
                n_row    = '0;
                n_pad    = '0;
                n_done   = 1'b0;
            end

            w_pix.green  = n_held2;
            w_pix.blue   = n_held1;
            w_pix.column = n_col;
            w_pix.row    = n_row;

            if (!n_done) begin
                v_pos = n_pos;
                if (v_pos != POS_MAX) begin
                    n_pos = v_pos + 32'd1;
                end

                if (v_pos < HDR_END) begin
                    // header: signature check and little-endian field capture
                    if (v_pos == SIG_POS_B && r_in_byte != SIG_B) begin
                        n_sigerr = 1'b1;
                    end
                    if (v_pos == SIG_POS_M && r_in_byte != SIG_M) begin
                        n_sigerr = 1'b1;
                    end
                    if (v_pos >= OFFS_POS && v_pos < OFFS_POS + 32'd4) begin
                        v_rel = v_pos - OFFS_POS;
                        n_offset[{v_rel[1:0], 3'b000} +: 8] = r_in_byte;
                    end
                    if (v_pos >= WIDTH_POS && v_pos < WIDTH_POS + 32'd4) begin
                        v_rel = v_pos - WIDTH_POS;
                        n_width[{v_rel[1:0], 3'b000} +: 8] = r_in_byte;
                    end
                    if (v_pos >= HEIGHT_POS && v_pos < HEIGHT_POS + 32'd4) begin
                        v_rel = v_pos - HEIGHT_POS;
                        n_height[{v_rel[1:0], 3'b000} +: 8] = r_in_byte;
                    end
                end else if (v_pos >= n_offset) begin
                    // past the header, so a small offset acts as the header end
                    v_size_bad = (n_width == '0) || (n_height == '0) ||
                                 (n_width > MAX_WIDTH) || (n_height > MAX_HEIGHT);
                    if (v_size_bad) begin
                        n_done = 1'b1;
                    end else if (n_pad != '0) begin
                        n_pad = n_pad - 2'd1;
                    end else begin
                        case (n_phase)
                            PH_FIRST: begin
                                n_held1 = r_in_byte;
                                n_phase = PH_SECOND;
                            end
                            PH_SECOND: begin
                                n_held2 = r_in_byte;
                                n_phase = PH_THIRD;
                            end
                            default: begin
                                n_phase   = PH_FIRST;
                                w_emit    = 1'b1;
                                v_row_end = ({{(32-COORD_W){1'b0}}, n_col} == n_width - 32'd1);
                                w_last    = v_row_end &&
                                    ({{(32-COORD_W){1'b0}}, n_row} == n_height - 32'd1);
                                if (w_last) begin
                                    n_done = 1'b1;
                                end else if (v_row_end) begin
                                    n_col = '0;
                                    n_row = n_row + COORD_W'(1);
                                    // row padding (4 - 3w mod 4) mod 4 equals w mod 4
                                    n_pad = n_width[1:0];
                                end else begin
                                    n_col = n_col + COORD_W'(1);
                                end
                            end
                        endcase
                    end
                end
            end
        end
    end

    // control and parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_offset    <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_sigerr    <= 1'b0;
            r_phase     <= PH_FIRST;
            r_held1     <= '0;
            r_held2     <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_pad       <= '0;
            r_done      <= 1'b1;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= w_fire && w_emit;
            end
            r_pos    <= n_pos;
            r_offset <= n_offset;
            r_width  <= n_width;
            r_height <= n_height;
            r_sigerr <= n_sigerr;
            r_phase  <= n_phase;
            r_held1  <= n_held1;
            r_held2  <= n_held2;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pad    <= n_pad;
            r_done   <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
        if (w_fire && w_emit) begin
            r_out_pix  <= w_pix;
            r_out_last <= w_last;
            r_out_bad  <= n_sigerr;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_bad;

endmodule
`default_nettype wire

>>> hdl/bmp24_chk.sv
`default_nettype none
`include "bmp24_pixel_stream_decoder_core_defines.svh"
module bmp24_chk
    import bmp24_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [PIX_W-1:0] m_axis_tdata,
    input wire logic             m_axis_tlast,
    input wire logic             m_axis_tuser
);

    t_pixel w_pix;

    assign w_pix = m_axis_tdata;

    // a stalled pixel transaction holds its payload
    `BMP24_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    // every pixel is fully opaque
    `BMP24_ASSERT_IMP(a_alpha, i_clk, i_rst_n, m_axis_tvalid, w_pix.alpha == ALPHA_OPAQUE)
    // nothing leaves the block right after reset
    `BMP24_ASSERT_NXT(a_rst_quiet, i_clk, 1'b1, !i_rst_n, !m_axis_tvalid)
    // the byte side is ready whenever the pixel side can move
    `BMP24_ASSERT_IMP(a_in_flow, i_clk, i_rst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready)

endmodule

bind bmp24_pixel_stream_decoder_core bmp24_chk u_bmp24_chk (.*);
`default_nettype wire
